// ----- rtl/dsf_pkg.sv -----
// ============================================================================
// dsf_pkg
// Shared widths, register codes and stage context for the damped spring force
// pipeline.
// ============================================================================
package dsf_pkg;

    // fixed-point formats
    localparam int FRAC_BITS = 16;
    localparam int UNIT_BITS = 30;

    // field widths
    localparam int POS_W     = 32;
    localparam int DIFF_W    = POS_W + 1;
    localparam int MAG_W     = 32;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int SUM_W     = SQ_W + 1;
    localparam int RAD_W     = 66;
    localparam int ROOT_W    = 33;
    localparam int REM_W     = ROOT_W + 3;
    localparam int UQ_W      = UNIT_BITS + 1;
    localparam int DREM_W    = ROOT_W + 1;
    localparam int REST_W    = 31;
    localparam int LEN_OUT_W = 31;
    localparam int CFG_W     = 32;
    localparam int IDX_W     = 4;

    // pipeline depth
    localparam int FRONT_STAGES = 4;
    localparam int SQRT_STAGES  = ROOT_W;
    localparam int DIV_STAGES   = UQ_W;
    localparam int BACK_STAGES  = 12;
    localparam int PIPE_DEPTH   = FRONT_STAGES + SQRT_STAGES + DIV_STAGES + BACK_STAGES;

    // register reset values: 400.0 and 10.0, all ones if they do not fit
    localparam logic [63:0] STIFF_WIDE = 64'd400 << FRAC_BITS;
    localparam logic [63:0] DAMP_WIDE  = 64'd10 << FRAC_BITS;
    localparam logic [CFG_W-1:0] STIFF_RESET =
        (STIFF_WIDE > 64'hFFFF_FFFF) ? {CFG_W{1'b1}} : STIFF_WIDE[CFG_W-1:0];
    localparam logic [CFG_W-1:0] DAMP_RESET =
        (DAMP_WIDE > 64'hFFFF_FFFF) ? {CFG_W{1'b1}} : DAMP_WIDE[CFG_W-1:0];

    typedef enum logic [IDX_W-1:0] {
        REG_STIFFNESS = 4'd0,
        REG_DAMPING   = 4'd1
    } cfg_reg_t;

    // what travels beside the square root and the divider
    typedef struct packed {
        logic [MAG_W-1:0]         mag_dx;
        logic [MAG_W-1:0]         mag_dy;
        logic                     neg_dx;
        logic                     neg_dy;
        logic signed [DIFF_W-1:0] dv_x;
        logic signed [DIFF_W-1:0] dv_y;
        logic [REST_W-1:0]        rest;
        logic [ROOT_W-1:0]        len;
    } ctx_t;

endpackage

// ----- rtl/dsf_sqrt.sv -----
// ============================================================================
// dsf_sqrt
// Pipelined floor square root, one root bit per stage.
// ============================================================================
module dsf_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [dsf_pkg::RAD_W-1:0]   in_rad,
    input  dsf_pkg::ctx_t               in_ctx,
    output logic                        out_valid,
    output logic [dsf_pkg::ROOT_W-1:0]  out_root,
    output dsf_pkg::ctx_t               out_ctx
);
    import dsf_pkg::*;

    logic              v_reg    [SQRT_STAGES];
    logic [RAD_W-1:0]  rad_reg  [SQRT_STAGES];
    logic [ROOT_W-1:0] root_reg [SQRT_STAGES];
    logic [REM_W-1:0]  rem_reg  [SQRT_STAGES];
    ctx_t              ctx_reg  [SQRT_STAGES];

    logic              v_src    [SQRT_STAGES];
    logic [RAD_W-1:0]  rad_src  [SQRT_STAGES];
    logic [ROOT_W-1:0] root_src [SQRT_STAGES];
    logic [REM_W-1:0]  rem_src  [SQRT_STAGES];
    ctx_t              ctx_src  [SQRT_STAGES];

    assign v_src[0]    = in_valid;
    assign rad_src[0]  = in_rad;
    assign root_src[0] = '0;
    assign rem_src[0]  = '0;
    assign ctx_src[0]  = in_ctx;

    for (genvar i = 0; i < SQRT_STAGES; i++)
    begin : g_stage
        logic [REM_W-1:0]  cur;
        logic [REM_W-1:0]  trial;
        logic              ge;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;
        logic [RAD_W-1:0]  rad_next;

        if (i > 0)
        begin : g_link
            assign v_src[i]    = v_reg[i-1];
            assign rad_src[i]  = rad_reg[i-1];
            assign root_src[i] = root_reg[i-1];
            assign rem_src[i]  = rem_reg[i-1];
            assign ctx_src[i]  = ctx_reg[i-1];
        end

        always_comb
        begin
            cur       = {rem_src[i][REM_W-3:0], rad_src[i][RAD_W-1 -: 2]};
            trial     = {{(REM_W-ROOT_W-2){1'b0}}, root_src[i], 2'b01};
            ge        = (cur >= trial);
            rem_next  = ge ? (cur - trial) : cur;
            root_next = {root_src[i][ROOT_W-2:0], ge};
            rad_next  = {rad_src[i][RAD_W-3:0], 2'b00};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else
            begin
                v_reg[i] <= v_src[i];
            end
        end

        always_ff @(posedge clk)
        begin
            rad_reg[i]  <= rad_next;
            root_reg[i] <= root_next;
            rem_reg[i]  <= rem_next;
            ctx_reg[i]  <= ctx_src[i];
        end
    end

    assign out_valid = v_reg[SQRT_STAGES-1];
    assign out_root  = root_reg[SQRT_STAGES-1];
    assign out_ctx   = ctx_reg[SQRT_STAGES-1];

endmodule

// ----- rtl/dsf_unit.sv -----
// ============================================================================
// dsf_unit
// Pipelined restoring divider for both unit vector components,
// |d| * 2^30 / len, one quotient bit per stage.
// ============================================================================
module dsf_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  dsf_pkg::ctx_t              in_ctx,
    output logic                       out_valid,
    output dsf_pkg::ctx_t              out_ctx,
    output logic [dsf_pkg::UQ_W-1:0]   out_qx,
    output logic [dsf_pkg::UQ_W-1:0]   out_qy
);
    import dsf_pkg::*;

    logic              v_reg   [DIV_STAGES];
    logic [DREM_W-1:0] rx_reg  [DIV_STAGES];
    logic [DREM_W-1:0] ry_reg  [DIV_STAGES];
    logic [UQ_W-1:0]   qx_reg  [DIV_STAGES];
    logic [UQ_W-1:0]   qy_reg  [DIV_STAGES];
    ctx_t              ctx_reg [DIV_STAGES];

    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_stage
        logic              v_src;
        ctx_t              ctx_src;
        logic [UQ_W-1:0]   qx_src;
        logic [UQ_W-1:0]   qy_src;
        logic [DREM_W-1:0] tx;
        logic [DREM_W-1:0] ty;
        logic [DREM_W-1:0] div_e;
        logic              gex;
        logic              gey;
        logic [DREM_W-1:0] rx_next;
        logic [DREM_W-1:0] ry_next;

        if (i == 0)
        begin : g_first
            // the whole magnitude enters at the top quotient bit
            assign v_src   = in_valid;
            assign ctx_src = in_ctx;
            assign qx_src  = '0;
            assign qy_src  = '0;
            assign tx      = {{(DREM_W-MAG_W){1'b0}}, in_ctx.mag_dx};
            assign ty      = {{(DREM_W-MAG_W){1'b0}}, in_ctx.mag_dy};
        end
        else
        begin : g_link
            assign v_src   = v_reg[i-1];
            assign ctx_src = ctx_reg[i-1];
            assign qx_src  = qx_reg[i-1];
            assign qy_src  = qy_reg[i-1];
            assign tx      = {rx_reg[i-1][DREM_W-2:0], 1'b0};
            assign ty      = {ry_reg[i-1][DREM_W-2:0], 1'b0};
        end

        always_comb
        begin
            div_e   = {{(DREM_W-ROOT_W){1'b0}}, ctx_src.len};
            gex     = (tx >= div_e);
            gey     = (ty >= div_e);
            rx_next = gex ? (tx - div_e) : tx;
            ry_next = gey ? (ty - div_e) : ty;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else
            begin
                v_reg[i] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            rx_reg[i]  <= rx_next;
            ry_reg[i]  <= ry_next;
            qx_reg[i]  <= {qx_src[UQ_W-2:0], gex};
            qy_reg[i]  <= {qy_src[UQ_W-2:0], gey};
            ctx_reg[i] <= ctx_src;
        end
    end

    assign out_valid = v_reg[DIV_STAGES-1];
    assign out_ctx   = ctx_reg[DIV_STAGES-1];
    assign out_qx    = qx_reg[DIV_STAGES-1];
    assign out_qy    = qy_reg[DIV_STAGES-1];

endmodule

// ----- rtl/damped_spring_force_2d.sv -----
// ============================================================================
// damped_spring_force_2d
// Hooke spring with dashpot damping in 2-D: length, unit vector and the force
// on both ends of one spring per cycle, fully pipelined.
// ============================================================================
//
// channel   | handshake                  | payload
// ----------+----------------------------+-------------------------------------
// request   | start, busy                | pos_*, vel_*, rest_length
// result    | result_valid (strobe)      | force_a_*, force_b_*, current_length,
//           |                            | degenerate
// config    | cfg_valid, cfg_ready       | cfg_index, cfg_data
//
// one request per cycle; busy is never raised, a request is taken whenever
// start is high
// each result passes through PIPE_DEPTH stages: 4 front
// stages, 33 square root stages, 31 divider stages and 12 force stages
// the square root and the divider each settle one bit per stage, so their
// result widths set the depth
// reset clears the valid bits and loads the default stiffness and damping
// results are strobes; the receiver cannot stall, so nothing in the pipe
// ever waits
//
module damped_spring_force_2d (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           start,
    output logic                           busy,
    input  logic signed [31:0]             pos_a_x,
    input  logic signed [31:0]             pos_a_y,
    input  logic signed [31:0]             pos_b_x,
    input  logic signed [31:0]             pos_b_y,
    input  logic signed [31:0]             vel_a_x,
    input  logic signed [31:0]             vel_a_y,
    input  logic signed [31:0]             vel_b_x,
    input  logic signed [31:0]             vel_b_y,
    input  logic [30:0]                    rest_length,

    output logic                           result_valid,
    output logic signed [31:0]             force_a_x,
    output logic signed [31:0]             force_a_y,
    output logic signed [31:0]             force_b_x,
    output logic signed [31:0]             force_b_y,
    output logic [30:0]                    current_length,
    output logic                           degenerate,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dsf_pkg::IDX_W-1:0]      cfg_index,
    input  logic [dsf_pkg::CFG_W-1:0]      cfg_data
);
    import dsf_pkg::*;

    // derived widths of the force path
    localparam int STRETCH_W = ROOT_W + 2;          // len - rest, signed
    localparam int STRM_W    = ROOT_W;              // |len - rest|
    localparam int PV_W      = UQ_W + MAG_W;        // u * dv
    localparam int TERM_W    = MAG_W + 1;           // one projected term, signed
    localparam int VR_W      = TERM_W + 1;          // relative speed, signed
    localparam int VRM_W     = VR_W - 1;
    localparam int PROD_W    = CFG_W + STRM_W;      // register times operand
    localparam int SPM_W     = PROD_W - FRAC_BITS;  // scaled magnitude
    localparam int SPR_W     = SPM_W + 1;           // scaled, signed
    localparam int TOT_W     = SPR_W + 1;           // total force, signed
    localparam int TOTM_W    = SPM_W + 1;
    localparam int LO_W      = (TOTM_W + 1) / 2;
    localparam int HI_W      = TOTM_W - LO_W;
    localparam int PH_W      = UQ_W + HI_W;
    localparam int PL_W      = UQ_W + LO_W;
    localparam int FULL_W    = UQ_W + TOTM_W;
    localparam int FM_W      = FULL_W - UNIT_BITS;

    localparam logic [UQ_W-1:0] UNIT_ONE = UQ_W'(1) << UNIT_BITS;
    localparam logic [FM_W-1:0] POS_LIM  = FM_W'(32'h7FFF_FFFF);
    localparam logic [FM_W-1:0] NEG_LIM  = FM_W'(33'h0_8000_0000);
    localparam logic [ROOT_W-1:0] LEN_LIM = ROOT_W'(31'h7FFF_FFFF);

    typedef struct packed {
        logic [UQ_W-1:0]   mu_x;
        logic [UQ_W-1:0]   mu_y;
        logic              un_x;
        logic              un_y;
        logic [ROOT_W-1:0] len;
        logic              degen;
    } back_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] stiff_reg;
    logic [CFG_W-1:0] damp_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiff_reg <= STIFF_RESET;
            damp_reg  <= DAMP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_STIFFNESS: stiff_reg <= cfg_data;
                REG_DAMPING:   damp_reg  <= cfg_data;
                default:       ;   // unknown index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // front: differences, magnitudes, squares, sum
    // ------------------------------------------------------------------
    logic                     s0_v_reg, s1_v_reg, s2_v_reg, s3_v_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    logic signed [DIFF_W-1:0] dvx_reg, dvy_reg;
    logic [REST_W-1:0]        rest_reg;
    ctx_t                     s1_ctx_reg, s2_ctx_reg, s3_ctx_reg;
    logic [SQ_W-1:0]          sqx_reg, sqy_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic [DIFF_W-1:0]        abs_dx, abs_dy;
    ctx_t                     s1_ctx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            s0_v_reg <= start && !busy;
            s1_v_reg <= s0_v_reg;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_comb
    begin
        abs_dx = dx_reg[DIFF_W-1] ? DIFF_W'(-dx_reg) : DIFF_W'(dx_reg);
        abs_dy = dy_reg[DIFF_W-1] ? DIFF_W'(-dy_reg) : DIFF_W'(dy_reg);
        s1_ctx_next.mag_dx = abs_dx[MAG_W-1:0];
        s1_ctx_next.mag_dy = abs_dy[MAG_W-1:0];
        s1_ctx_next.neg_dx = dx_reg[DIFF_W-1];
        s1_ctx_next.neg_dy = dy_reg[DIFF_W-1];
        s1_ctx_next.dv_x   = dvx_reg;
        s1_ctx_next.dv_y   = dvy_reg;
        s1_ctx_next.rest   = rest_reg;
        s1_ctx_next.len    = '0;
    end

    always_ff @(posedge clk)
    begin
        // stage 0: differences, sign extended so nothing is lost
        dx_reg   <= $signed({pos_b_x[POS_W-1], pos_b_x}) - $signed({pos_a_x[POS_W-1], pos_a_x});
        dy_reg   <= $signed({pos_b_y[POS_W-1], pos_b_y}) - $signed({pos_a_y[POS_W-1], pos_a_y});
        dvx_reg  <= $signed({vel_b_x[POS_W-1], vel_b_x}) - $signed({vel_a_x[POS_W-1], vel_a_x});
        dvy_reg  <= $signed({vel_b_y[POS_W-1], vel_b_y}) - $signed({vel_a_y[POS_W-1], vel_a_y});
        rest_reg <= rest_length;
        // stage 1: magnitudes
        s1_ctx_reg <= s1_ctx_next;
        // stage 2: squares
        sqx_reg    <= SQ_W'(s1_ctx_reg.mag_dx) * SQ_W'(s1_ctx_reg.mag_dx);
        sqy_reg    <= SQ_W'(s1_ctx_reg.mag_dy) * SQ_W'(s1_ctx_reg.mag_dy);
        s2_ctx_reg <= s1_ctx_reg;
        // stage 3: sum of squares with carry
        sum_reg    <= SUM_W'(sqx_reg) + SUM_W'(sqy_reg);
        s3_ctx_reg <= s2_ctx_reg;
    end

    // ------------------------------------------------------------------
    // square root, then the unit vector divider
    // ------------------------------------------------------------------
    logic              sq_v;
    logic [ROOT_W-1:0] sq_root;
    ctx_t              sq_ctx;
    ctx_t              dv_ctx_in;
    logic              un_v;
    ctx_t              un_ctx;
    logic [UQ_W-1:0]   un_qx, un_qy;

    dsf_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_v_reg),
        .in_rad    (RAD_W'(sum_reg)),
        .in_ctx    (s3_ctx_reg),
        .out_valid (sq_v),
        .out_root  (sq_root),
        .out_ctx   (sq_ctx)
    );

    always_comb
    begin
        dv_ctx_in     = sq_ctx;
        dv_ctx_in.len = sq_root;
    end

    dsf_unit u_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_v),
        .in_ctx    (dv_ctx_in),
        .out_valid (un_v),
        .out_ctx   (un_ctx),
        .out_qx    (un_qx),
        .out_qy    (un_qy)
    );

    // ------------------------------------------------------------------
    // force stages p1..p12
    // ------------------------------------------------------------------
    logic  pv_reg [BACK_STAGES];
    back_t bk_reg [BACK_STAGES];
    back_t bk_next;

    logic [UQ_W-1:0]   mux_clamp, muy_clamp;

    // p1
    logic [MAG_W-1:0]            mdvx_reg, mdvy_reg;
    logic                        dvnx_reg, dvny_reg;
    logic signed [STRETCH_W-1:0] stretch_reg;
    logic [DIFF_W-1:0]           abs_dvx, abs_dvy;
    // p2
    logic [PV_W-1:0]             pvx_reg, pvy_reg;
    logic                        tnx_reg, tny_reg;
    logic [STRM_W-1:0]           strm_reg;
    logic                        strn_reg;
    logic [STRETCH_W-1:0]        abs_str;
    // p3
    logic signed [TERM_W-1:0]    termx_reg, termy_reg;
    logic [PROD_W-1:0]           sprod_reg;
    logic                        strn3_reg;
    // p4
    logic signed [VR_W-1:0]      vr_reg;
    logic [SPM_W-1:0]            spm_reg;
    logic                        spn_reg;
    // p5
    logic [VRM_W-1:0]            vrm_reg;
    logic                        vrn_reg;
    logic signed [SPR_W-1:0]     spring_reg;
    logic [VR_W-1:0]             abs_vr;
    // p6
    logic [PROD_W-1:0]           dprod_reg;
    logic                        vrn6_reg;
    logic signed [SPR_W-1:0]     spring6_reg;
    // p7
    logic signed [SPR_W-1:0]     damp_reg7;
    logic signed [SPR_W-1:0]     spring7_reg;
    // p8
    logic signed [TOT_W-1:0]     total_reg;
    // p9
    logic [TOTM_W-1:0]           totm_reg;
    logic                        totn_reg;
    logic [TOT_W-1:0]            abs_tot;
    // p10
    logic [PH_W-1:0]             phx_reg, phy_reg;
    logic [PL_W-1:0]             plx_reg, ply_reg;
    logic                        fnx_reg, fny_reg;
    // p11
    logic [FM_W-1:0]             fmx_reg, fmy_reg;
    logic                        fnx11_reg, fny11_reg;
    logic [FULL_W-1:0]           fullx, fully;
    // p12 outputs
    logic signed [31:0]          fax_next, fay_next, fbx_next, fby_next;
    logic signed [31:0]          fax_reg, fay_reg, fbx_reg, fby_reg;
    logic [LEN_OUT_W-1:0]        len_reg;
    logic                        degen_reg;

    // clamp of each quotient to one; the sign only counts for a nonzero value
    always_comb
    begin
        mux_clamp = (un_qx > UNIT_ONE) ? UNIT_ONE : un_qx;
        muy_clamp = (un_qy > UNIT_ONE) ? UNIT_ONE : un_qy;
        bk_next.mu_x  = mux_clamp;
        bk_next.mu_y  = muy_clamp;
        bk_next.un_x  = un_ctx.neg_dx && (mux_clamp != '0);
        bk_next.un_y  = un_ctx.neg_dy && (muy_clamp != '0);
        bk_next.len   = un_ctx.len;
        bk_next.degen = (un_ctx.len == '0);
        abs_dvx = un_ctx.dv_x[DIFF_W-1] ? DIFF_W'(-un_ctx.dv_x) : DIFF_W'(un_ctx.dv_x);
        abs_dvy = un_ctx.dv_y[DIFF_W-1] ? DIFF_W'(-un_ctx.dv_y) : DIFF_W'(un_ctx.dv_y);
        abs_str = stretch_reg[STRETCH_W-1] ? STRETCH_W'(-stretch_reg)
                                           : STRETCH_W'(stretch_reg);
        abs_vr  = vr_reg[VR_W-1] ? VR_W'(-vr_reg) : VR_W'(vr_reg);
        abs_tot = total_reg[TOT_W-1] ? TOT_W'(-total_reg) : TOT_W'(total_reg);
        fullx   = (FULL_W'(phx_reg) << LO_W) + FULL_W'(plx_reg);
        fully   = (FULL_W'(phy_reg) << LO_W) + FULL_W'(ply_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < BACK_STAGES; k++)
            begin
                pv_reg[k] <= 1'b0;
            end
        end
        else
        begin
            pv_reg[0] <= un_v;
            for (int k = 1; k < BACK_STAGES; k++)
            begin
                pv_reg[k] <= pv_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bk_reg[0] <= bk_next;
        for (int k = 1; k < BACK_STAGES; k++)
        begin
            bk_reg[k] <= bk_reg[k-1];
        end

        // p1: velocity magnitudes and stretch
        mdvx_reg    <= abs_dvx[MAG_W-1:0];
        mdvy_reg    <= abs_dvy[MAG_W-1:0];
        dvnx_reg    <= un_ctx.dv_x[DIFF_W-1];
        dvny_reg    <= un_ctx.dv_y[DIFF_W-1];
        stretch_reg <= $signed({2'b00, un_ctx.len})
                     - $signed({{(STRETCH_W-REST_W){1'b0}}, un_ctx.rest});

        // p2: projections of the relative velocity
        pvx_reg  <= PV_W'(bk_reg[0].mu_x) * PV_W'(mdvx_reg);
        pvy_reg  <= PV_W'(bk_reg[0].mu_y) * PV_W'(mdvy_reg);
        tnx_reg  <= bk_reg[0].un_x ^ dvnx_reg;
        tny_reg  <= bk_reg[0].un_y ^ dvny_reg;
        strm_reg <= abs_str[STRM_W-1:0];
        strn_reg <= stretch_reg[STRETCH_W-1];

        // p3: drop the unit fraction, truncating each term toward zero; spring product
        termx_reg <= tnx_reg ? -$signed({1'b0, pvx_reg[UNIT_BITS +: MAG_W]})
                             :  $signed({1'b0, pvx_reg[UNIT_BITS +: MAG_W]});
        termy_reg <= tny_reg ? -$signed({1'b0, pvy_reg[UNIT_BITS +: MAG_W]})
                             :  $signed({1'b0, pvy_reg[UNIT_BITS +: MAG_W]});
        sprod_reg <= PROD_W'(stiff_reg) * PROD_W'(strm_reg);
        strn3_reg <= strn_reg;

        // p4: relative speed along the spring
        vr_reg  <= VR_W'(termx_reg) + VR_W'(termy_reg);
        spm_reg <= sprod_reg[PROD_W-1:FRAC_BITS];
        spn_reg <= strn3_reg;

        // p5
        vrm_reg    <= abs_vr[VRM_W-1:0];
        vrn_reg    <= vr_reg[VR_W-1];
        spring_reg <= spn_reg ? -$signed({1'b0, spm_reg}) : $signed({1'b0, spm_reg});

        // p6: damping product
        dprod_reg   <= PROD_W'(damp_reg) * PROD_W'(vrm_reg);
        vrn6_reg    <= vrn_reg;
        spring6_reg <= spring_reg;

        // p7
        damp_reg7   <= vrn6_reg ? -$signed({1'b0, dprod_reg[PROD_W-1:FRAC_BITS]})
                                :  $signed({1'b0, dprod_reg[PROD_W-1:FRAC_BITS]});
        spring7_reg <= spring6_reg;

        // p8: total tension
        total_reg <= TOT_W'(spring7_reg) + TOT_W'(damp_reg7);

        // p9
        totm_reg <= abs_tot[TOTM_W-1:0];
        totn_reg <= total_reg[TOT_W-1];

        // p10: u times total, split into two partial products
        phx_reg <= PH_W'(bk_reg[8].mu_x) * PH_W'(totm_reg[TOTM_W-1:LO_W]);
        plx_reg <= PL_W'(bk_reg[8].mu_x) * PL_W'(totm_reg[LO_W-1:0]);
        phy_reg <= PH_W'(bk_reg[8].mu_y) * PH_W'(totm_reg[TOTM_W-1:LO_W]);
        ply_reg <= PL_W'(bk_reg[8].mu_y) * PL_W'(totm_reg[LO_W-1:0]);
        fnx_reg <= bk_reg[8].un_x ^ totn_reg;
        fny_reg <= bk_reg[8].un_y ^ totn_reg;

        // p11: combine and drop the unit fraction
        fmx_reg   <= fullx[FULL_W-1:UNIT_BITS];
        fmy_reg   <= fully[FULL_W-1:UNIT_BITS];
        fnx11_reg <= fnx_reg;
        fny11_reg <= fny_reg;

        // p12: saturated outputs
        fax_reg   <= fax_next;
        fay_reg   <= fay_next;
        fbx_reg   <= fbx_next;
        fby_reg   <= fby_next;
        len_reg   <= (bk_reg[10].len > LEN_LIM) ? LEN_OUT_W'(LEN_LIM)
                                                : bk_reg[10].len[LEN_OUT_W-1:0];
        degen_reg <= bk_reg[10].degen;
    end

    // saturation from magnitude and sign; b is the negation of the raw a force
    always_comb
    begin
        if (bk_reg[10].degen)
        begin
            fax_next = '0;
            fay_next = '0;
            fbx_next = '0;
            fby_next = '0;
        end
        else
        begin
            if (!fnx11_reg)
            begin
                fax_next = (fmx_reg > POS_LIM) ? 32'sh7FFF_FFFF : $signed(fmx_reg[31:0]);
                fbx_next = (fmx_reg > NEG_LIM) ? 32'sh8000_0000 : -$signed(fmx_reg[31:0]);
            end
            else
            begin
                fax_next = (fmx_reg > NEG_LIM) ? 32'sh8000_0000 : -$signed(fmx_reg[31:0]);
                fbx_next = (fmx_reg > POS_LIM) ? 32'sh7FFF_FFFF : $signed(fmx_reg[31:0]);
            end
            if (!fny11_reg)
            begin
                fay_next = (fmy_reg > POS_LIM) ? 32'sh7FFF_FFFF : $signed(fmy_reg[31:0]);
                fby_next = (fmy_reg > NEG_LIM) ? 32'sh8000_0000 : -$signed(fmy_reg[31:0]);
            end
            else
            begin
                fay_next = (fmy_reg > NEG_LIM) ? 32'sh8000_0000 : -$signed(fmy_reg[31:0]);
                fby_next = (fmy_reg > POS_LIM) ? 32'sh7FFF_FFFF : $signed(fmy_reg[31:0]);
            end
        end
    end

    assign result_valid   = pv_reg[BACK_STAGES-1];
    assign force_a_x      = fax_reg;
    assign force_a_y      = fay_reg;
    assign force_b_x      = fbx_reg;
    assign force_b_y      = fby_reg;
    assign current_length = len_reg;
    assign degenerate     = degen_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_DEPTH result_valid)
        else $error("request did not produce a result after the pipeline depth");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && degenerate) |->
        (force_a_x == 0 && force_a_y == 0 && force_b_x == 0 && force_b_y == 0
         && current_length == 0))
        else $error("degenerate result with nonzero fields");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !degenerate) |-> (current_length != 0))
        else $error("zero length without degenerate flag");

    a_neg_x: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && force_a_x != 32'sh7FFF_FFFF && force_a_x != 32'sh8000_0000)
        |-> (force_b_x == -force_a_x))
        else $error("x force on b is not the negation of a");

    a_neg_y: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && force_a_y != 32'sh7FFF_FFFF && force_a_y != 32'sh8000_0000)
        |-> (force_b_y == -force_a_y))
        else $error("y force on b is not the negation of a");

endmodule
